### design/julian_day_to_gregorian_top_macros.svh
// Assertion macros for the Julian day to Gregorian date converter.
`ifndef JULIAN_DAY_TO_GREGORIAN_TOP_MACROS_SVH
`define JULIAN_DAY_TO_GREGORIAN_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define JDG_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
    else $error("jdg assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define JDG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
    else $error("jdg assertion failed");

`endif

### design/jdg_pkg.sv
// Shared constants for the Julian day to Gregorian date converter.
package jdg_pkg;

  localparam int JD_W    = 22;
  localparam int FRAC_W  = 32;
  localparam int YEAR_W  = 12;
  localparam int MONTH_W = 4;
  localparam int MDAY_W  = 5;
  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;
  localparam int SEC_W   = 6;

  localparam int SECS_PER_DAY  = 86400;
  localparam int SECS_PER_HOUR = 3600;
  localparam int SECS_PER_MIN  = 60;
  localparam int JD_EPOCH      = 2415079;
  localparam int DAY_COUNT_MAX = 73049;
  localparam int DAYS_PER_4Y   = 1461;
  localparam int DAYS_PER_5M   = 153;
  localparam int YEAR_BASE     = 1900;
  localparam int MONTH_MARCH   = 3;
  localparam int MONTH_WRAP    = 10;
  localparam int MONTH_SHIFT   = 9;

  localparam int RECIP_SHIFT = 20;
  localparam int DIV5_SHIFT  = 10;

  localparam int PIPE_DEPTH = 6;

endpackage

### design/julian_day_to_gregorian_top.sv
// Julian day to Gregorian date and time of day converter, six-stage pipeline.
//
// Converts a noon-based Julian day number and a Q0.32 day fraction into a UTC
// calendar date and whole-second time of day. A transaction is accepted when
// start is high and busy is low; busy is high only during reset, so one
// transaction can be accepted every cycle. Each result appears on the out_
// ports from the last pipeline register, marked by out_valid for one cycle,
// in order; the receiver cannot stall and must take it then. The pipeline depth
// is set by the chain of reciprocal-multiply divisions (by 3600, 60, 1461 and
// 153), each estimate followed by a single compare-and-subtract correction.
// Dates outside 1900-03-01 to 2100-02-28 set out_range_error and return zero
// in year, month and day; the time fields are always valid.
module julian_day_to_gregorian_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [jdg_pkg::JD_W-1:0]    in_julian_day,
  input  logic [jdg_pkg::FRAC_W-1:0]  in_day_fraction,
  output logic                        out_valid,
  output logic [jdg_pkg::YEAR_W-1:0]  out_year,
  output logic [jdg_pkg::MONTH_W-1:0] out_month,
  output logic [jdg_pkg::MDAY_W-1:0]  out_day_of_month,
  output logic [jdg_pkg::HOUR_W-1:0]  out_hour,
  output logic [jdg_pkg::MIN_W-1:0]   out_minute,
  output logic [jdg_pkg::SEC_W-1:0]   out_second,
  output logic                        out_range_error
);
  import jdg_pkg::*;

  localparam int SECS_W  = 17;
  localparam int PROD_W  = FRAC_W + SECS_W;
  localparam int D_W     = 24;
  localparam int DN_W    = 19;
  localparam int YOFF_W  = 8;
  localparam int YREM_W  = 11;
  localparam int TREM_W  = 12;
  localparam int TDAY_W  = 9;
  localparam int MN_W    = 11;
  localparam int MREM_W  = 8;
  localparam int HP_W    = SECS_W + 10;
  localparam int MP_W    = TREM_W + 16;
  localparam int YP_W    = DN_W + 11;
  localparam int MDP_W   = MN_W + 14;
  localparam int DP_W    = 16;

  localparam int HOUR_K = (1 << RECIP_SHIFT) / SECS_PER_HOUR;
  localparam int MIN_K  = (1 << RECIP_SHIFT) / SECS_PER_MIN;
  localparam int YEAR_K = (1 << RECIP_SHIFT) / DAYS_PER_4Y;
  localparam int MON_K  = (1 << RECIP_SHIFT) / DAYS_PER_5M;
  localparam int DIV5_K = (1 << DIV5_SHIFT) / 5 + 1;

  logic [PIPE_DEPTH-1:0] vld_r, vld_nxt;
  logic                  accept;

  // stage 1
  logic [FRAC_W-1:0] frac_mid;
  logic              carry;
  logic [D_W-1:0]    day_cnt;
  logic [PROD_W-1:0] prod1_nxt, prod1_r;
  logic [DN_W-1:0]   n1_nxt, n1_r;
  logic              err1_nxt, err1_r;

  // stage 2
  logic [SECS_W-1:0] secs;
  logic [HP_W-1:0]   hprod;
  logic [YP_W-1:0]   yprod;
  logic [SECS_W-1:0] secs2_r;
  logic [HOUR_W-1:0] hest2_nxt, hest2_r;
  logic [DN_W-1:0]   n2_r;
  logic [YOFF_W-1:0] yest2_nxt, yest2_r;
  logic              err2_r;

  // stage 3
  logic [SECS_W-1:0] trem;
  logic              tcorr;
  logic [DN_W-1:0]   yrem;
  logic              ycorr;
  logic [HOUR_W-1:0] hour3_nxt, hour3_r;
  logic [TREM_W-1:0] trem3_nxt, trem3_r;
  logic [YOFF_W-1:0] yoff3_nxt, yoff3_r;
  logic [YREM_W-1:0] yrem3_nxt, yrem3_r;
  logic              err3_r;

  // stage 4
  logic [MP_W-1:0]    mprod;
  logic [TDAY_W-1:0]  tday;
  logic [MN_W-1:0]    mnum4_nxt, mnum4_r;
  logic [MDP_W-1:0]   mdprod;
  logic [HOUR_W-1:0]  hour4_r;
  logic [TREM_W-1:0]  trem4_r;
  logic [MIN_W-1:0]   mest4_nxt, mest4_r;
  logic [YOFF_W-1:0]  yoff4_r;
  logic [MONTH_W-1:0] mon_est4_nxt, mon_est4_r;
  logic               err4_r;

  // stage 5
  logic [TREM_W-1:0]  srem;
  logic               scorr;
  logic [MN_W-1:0]    mrem;
  logic               mcorr;
  logic [HOUR_W-1:0]  hour5_r;
  logic [MIN_W-1:0]   min5_nxt, min5_r;
  logic [SEC_W-1:0]   sec5_nxt, sec5_r;
  logic [YOFF_W-1:0]  yoff5_r;
  logic [MONTH_W-1:0] mon5_nxt, mon5_r;
  logic [MREM_W-1:0]  mrem5_nxt, mrem5_r;
  logic               err5_r;

  // stage 6
  logic [DP_W-1:0]    dprod;
  logic               late;
  logic [YEAR_W-1:0]  year_nxt, year_r;
  logic [MONTH_W-1:0] month_nxt, month_r;
  logic [MDAY_W-1:0]  mday_nxt, mday_r;
  logic [HOUR_W-1:0]  hour6_r;
  logic [MIN_W-1:0]   min6_r;
  logic [SEC_W-1:0]   sec6_r;
  logic               err6_r;

  assign busy    = ~rst_n;
  assign accept  = start & ~busy;
  assign vld_nxt = {vld_r[PIPE_DEPTH-2:0], accept};

  // stage 1: half-day shift, seconds product, day count and range check
  always_comb begin
    frac_mid  = {~in_day_fraction[FRAC_W-1], in_day_fraction[FRAC_W-2:0]};
    carry     = in_day_fraction[FRAC_W-1];
    prod1_nxt = PROD_W'(frac_mid) * PROD_W'(SECS_PER_DAY);
    day_cnt   = D_W'(in_julian_day) + D_W'(carry) - D_W'(JD_EPOCH);
    err1_nxt  = (day_cnt == '0) | (day_cnt > D_W'(DAY_COUNT_MAX));
    n1_nxt    = DN_W'({day_cnt[DN_W-3:0], 2'b00}) - DN_W'(1);
  end

  // stage 2: seconds of day, hour and year-offset estimates
  always_comb begin
    secs      = SECS_W'((prod1_r + PROD_W'(1)) >> FRAC_W);
    hprod     = HP_W'(secs) * HP_W'(HOUR_K);
    hest2_nxt = HOUR_W'(hprod >> RECIP_SHIFT);
    yprod     = YP_W'(n1_r) * YP_W'(YEAR_K);
    yest2_nxt = YOFF_W'(yprod >> RECIP_SHIFT);
  end

  // stage 3: correct hour and year offset
  always_comb begin
    trem      = secs2_r - SECS_W'(hest2_r) * SECS_W'(SECS_PER_HOUR);
    tcorr     = trem >= SECS_W'(SECS_PER_HOUR);
    hour3_nxt = hest2_r + HOUR_W'(tcorr);
    trem3_nxt = tcorr ? TREM_W'(trem - SECS_W'(SECS_PER_HOUR)) : TREM_W'(trem);
    yrem      = n2_r - DN_W'(yest2_r) * DN_W'(DAYS_PER_4Y);
    ycorr     = yrem >= DN_W'(DAYS_PER_4Y);
    yoff3_nxt = yest2_r + YOFF_W'(ycorr);
    yrem3_nxt = ycorr ? YREM_W'(yrem - DN_W'(DAYS_PER_4Y)) : YREM_W'(yrem);
  end

  // stage 4: minute estimate, day of year, month estimate
  always_comb begin
    mprod        = MP_W'(trem3_r) * MP_W'(MIN_K);
    mest4_nxt    = MIN_W'(mprod >> RECIP_SHIFT);
    tday         = TDAY_W'((TREM_W'(yrem3_r) + TREM_W'(4)) >> 2);
    mnum4_nxt    = MN_W'(tday) * MN_W'(5) - MN_W'(3);
    mdprod       = MDP_W'(mnum4_nxt) * MDP_W'(MON_K);
    mon_est4_nxt = MONTH_W'(mdprod >> RECIP_SHIFT);
  end

  // stage 5: correct minute and month
  always_comb begin
    srem      = trem4_r - TREM_W'(mest4_r) * TREM_W'(SECS_PER_MIN);
    scorr     = srem >= TREM_W'(SECS_PER_MIN);
    min5_nxt  = mest4_r + MIN_W'(scorr);
    sec5_nxt  = scorr ? SEC_W'(srem - TREM_W'(SECS_PER_MIN)) : SEC_W'(srem);
    mrem      = mnum4_r - MN_W'(mon_est4_r) * MN_W'(DAYS_PER_5M);
    mcorr     = mrem >= MN_W'(DAYS_PER_5M);
    mon5_nxt  = mon_est4_r + MONTH_W'(mcorr);
    mrem5_nxt = mcorr ? MREM_W'(mrem - MN_W'(DAYS_PER_5M)) : MREM_W'(mrem);
  end

  // stage 6: day of month, March-based month back to January-based
  always_comb begin
    // x / 5 as (x * 205) >> 10, exact for x below 1024
    dprod = (DP_W'(mrem5_r) + DP_W'(5)) * DP_W'(DIV5_K);
    late  = mon5_r >= MONTH_W'(MONTH_WRAP);
    if (err5_r) begin
      year_nxt  = '0;
      month_nxt = '0;
      mday_nxt  = '0;
    end else begin
      year_nxt  = YEAR_W'(YEAR_BASE) + YEAR_W'(yoff5_r) + YEAR_W'(late);
      month_nxt = late ? mon5_r - MONTH_W'(MONTH_SHIFT) : mon5_r + MONTH_W'(MONTH_MARCH);
      mday_nxt  = MDAY_W'(dprod >> DIV5_SHIFT);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod1_r    <= prod1_nxt;
    n1_r       <= n1_nxt;
    err1_r     <= err1_nxt;

    secs2_r    <= secs;
    hest2_r    <= hest2_nxt;
    n2_r       <= n1_r;
    yest2_r    <= yest2_nxt;
    err2_r     <= err1_r;

    hour3_r    <= hour3_nxt;
    trem3_r    <= trem3_nxt;
    yoff3_r    <= yoff3_nxt;
    yrem3_r    <= yrem3_nxt;
    err3_r     <= err2_r;

    hour4_r    <= hour3_r;
    trem4_r    <= trem3_r;
    mest4_r    <= mest4_nxt;
    yoff4_r    <= yoff3_r;
    mnum4_r    <= mnum4_nxt;
    mon_est4_r <= mon_est4_nxt;
    err4_r     <= err3_r;

    hour5_r    <= hour4_r;
    min5_r     <= min5_nxt;
    sec5_r     <= sec5_nxt;
    yoff5_r    <= yoff4_r;
    mon5_r     <= mon5_nxt;
    mrem5_r    <= mrem5_nxt;
    err5_r     <= err4_r;

    year_r     <= year_nxt;
    month_r    <= month_nxt;
    mday_r     <= mday_nxt;
    hour6_r    <= hour5_r;
    min6_r     <= min5_r;
    sec6_r     <= sec5_r;
    err6_r     <= err5_r;
  end

  assign out_valid        = vld_r[PIPE_DEPTH-1];
  assign out_year         = year_r;
  assign out_month        = month_r;
  assign out_day_of_month = mday_r;
  assign out_hour         = hour6_r;
  assign out_minute       = min6_r;
  assign out_second       = sec6_r;
  assign out_range_error  = err6_r;

endmodule

### design/jdg_checker.sv
// Port-level assertion checker for the Julian day converter, with its bind.
`include "julian_day_to_gregorian_top_macros.svh"

module jdg_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input logic [jdg_pkg::JD_W-1:0]    in_julian_day,
  input logic [jdg_pkg::FRAC_W-1:0]  in_day_fraction,
  input logic                        out_valid,
  input logic [jdg_pkg::YEAR_W-1:0]  out_year,
  input logic [jdg_pkg::MONTH_W-1:0] out_month,
  input logic [jdg_pkg::MDAY_W-1:0]  out_day_of_month,
  input logic [jdg_pkg::HOUR_W-1:0]  out_hour,
  input logic [jdg_pkg::MIN_W-1:0]   out_minute,
  input logic [jdg_pkg::SEC_W-1:0]   out_second,
  input logic                        out_range_error
);
  import jdg_pkg::*;

  logic in_xact;
  logic date_zero;
  logic date_in_span;
  logic time_legal;

  assign in_xact = start & ~busy & (in_julian_day == in_julian_day)
                   & (in_day_fraction == in_day_fraction);

  assign date_zero    = (out_year == '0) && (out_month == '0) && (out_day_of_month == '0);
  assign date_in_span = (out_year >= YEAR_W'(YEAR_BASE)) && (out_year <= YEAR_W'(2100)) &&
                        (out_month >= MONTH_W'(1)) && (out_month <= MONTH_W'(12)) &&
                        (out_day_of_month != '0);
  assign time_legal   = (out_hour <= HOUR_W'(23)) && (out_minute <= MIN_W'(59)) &&
                        (out_second <= SEC_W'(59));

  // every transaction comes out after the fixed pipeline latency
  `JDG_ASSERT_NOW(a_latency, in_xact, ##PIPE_DEPTH out_valid)

  // out-of-range dates carry a zero date
  `JDG_ASSERT_NOW(a_err_zero, out_valid && out_range_error, date_zero)

  // in-range dates stay in the calendar span
  `JDG_ASSERT_NOW(a_date_ok, out_valid && !out_range_error, date_in_span)

  // time of day always legal
  `JDG_ASSERT_NOW(a_time_ok, out_valid, time_legal)

endmodule

bind julian_day_to_gregorian_top jdg_checker u_jdg_checker (.*);
